[rtl/deq_pkg.sv]
`timescale 1ns / 1ps
// Package: operation codes, word types and defaults for the double-ended queue.
package deq_pkg;

    localparam int DEPTH_DEFAULT      = 1024;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int OP_W               = 3;
    localparam int VALUE_W            = 32;
    localparam int COUNT_W            = 11;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_PEEK_FRONT = 3'd4,
        OP_PEEK_BACK  = 3'd5,
        OP_STATUS     = 3'd6
    } deq_op_t;

    typedef struct packed {
        logic [OP_W-1:0]    operation;
        logic [VALUE_W-1:0] push_value;
    } deq_in_t;

    typedef struct packed {
        logic [VALUE_W-1:0] read_value;
        logic               read_miss;
        logic               push_dropped;
        logic [COUNT_W-1:0] element_count;
        logic               is_empty;
    } deq_out_t;

    typedef struct packed {
        logic shift_r;
        logic shift_l;
        logic wr_at;
    } deq_cell_ctrl_t;

endpackage

[rtl/deq_cell.sv]
`timescale 1ns / 1ps
// One storage cell of a chain: shift in from either neighbor or load at its own index.
module deq_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 11,
    parameter int INDEX      = 0
) (
    input  logic                    aclk,
    input  deq_pkg::deq_cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]        wr_index,
    input  logic [DATA_WIDTH-1:0]   wr_data,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    output logic [DATA_WIDTH-1:0]   data_out
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_r) begin
            data_next = left_data;
        end else if (ctrl.shift_l) begin
            data_next = right_data;
        end else if (ctrl.wr_at && (wr_index == CNT_W'(INDEX))) begin
            data_next = wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule

[rtl/deq_chain.sv]
`timescale 1ns / 1ps
// Row of cells holding the queue in order from one end; cell zero is that end.
module deq_chain #(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32,
    parameter int CNT_W      = 11
) (
    input  logic                    aclk,
    input  deq_pkg::deq_cell_ctrl_t ctrl,
    input  logic [CNT_W-1:0]        wr_index,
    input  logic [DATA_WIDTH-1:0]   in_data,
    output logic [DATA_WIDTH-1:0]   head_data
);
    import deq_pkg::*;

    logic [DATA_WIDTH-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        if (i == 0) begin : g_first
            assign left_w = in_data;
        end else begin : g_mid_l
            assign left_w = cell_data[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_mid_r
            assign right_w = cell_data[i+1];
        end

        deq_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .CNT_W      (CNT_W),
            .INDEX      (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .wr_index   (wr_index),
            .wr_data    (in_data),
            .left_data  (left_w),
            .right_data (right_w),
            .data_out   (cell_data[i])
        );
    end

    assign head_data = cell_data[0];

endmodule

[rtl/double_ended_queue.sv]
`timescale 1ns / 1ps
// Double-ended queue built from two mirrored cell chains, front-first and back-first.
// An accepted word's result is registered and shown on m_data in the cycle after it is accepted.
// Throughput: one word per cycle unless m_ready stalls; both ends sit at cell zero of a chain.
// Reset: clears the element count and the output valid; stored cell data is not cleared.
// Storage: two chains of DEPTH cells each, DATA_WIDTH bits per cell.
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  deq_pkg::deq_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output deq_pkg::deq_out_t m_data
);
    import deq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  m_valid_reg;
    logic                  m_valid_next;
    deq_out_t              m_data_reg;
    deq_out_t              m_data_next;

    logic                  accept;
    logic                  full;
    logic                  empty;
    logic [OP_W-1:0]       op;
    logic [DATA_WIDTH-1:0] push_data;
    logic [DATA_WIDTH-1:0] front_data;
    logic [DATA_WIDTH-1:0] back_data;
    logic [DATA_WIDTH-1:0] rd_data;
    logic                  miss;
    logic                  dropped;
    deq_cell_ctrl_t        front_ctrl;
    deq_cell_ctrl_t        back_ctrl;

    assign op        = s_data.operation;
    assign push_data = DATA_WIDTH'(s_data.push_value);
    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);

    always_comb begin
        front_ctrl = '0;
        back_ctrl  = '0;
        count_next = count_reg;
        rd_data    = '0;
        miss       = 1'b0;
        dropped    = 1'b0;
        case (op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    dropped = 1'b1;
                end else begin
                    front_ctrl.shift_r = accept;
                    back_ctrl.wr_at    = accept;
                    count_next         = count_reg + CNT_W'(1);
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    dropped = 1'b1;
                end else begin
                    back_ctrl.shift_r = accept;
                    front_ctrl.wr_at  = accept;
                    count_next        = count_reg + CNT_W'(1);
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    miss = 1'b1;
                end else begin
                    rd_data            = front_data;
                    front_ctrl.shift_l = accept;
                    count_next         = count_reg - CNT_W'(1);
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    miss = 1'b1;
                end else begin
                    rd_data           = back_data;
                    back_ctrl.shift_l = accept;
                    count_next        = count_reg - CNT_W'(1);
                end
            end
            OP_PEEK_FRONT: begin
                if (empty) begin
                    miss = 1'b1;
                end else begin
                    rd_data = front_data;
                end
            end
            OP_PEEK_BACK: begin
                if (empty) begin
                    miss = 1'b1;
                end else begin
                    rd_data = back_data;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next               = 1'b1;
            m_data_next.read_value     = VALUE_W'(rd_data);
            m_data_next.read_miss      = miss;
            m_data_next.push_dropped   = dropped;
            m_data_next.element_count  = COUNT_W'(count_next);
            m_data_next.is_empty       = (count_next == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    deq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_front_chain (
        .aclk      (aclk),
        .ctrl      (front_ctrl),
        .wr_index  (count_reg),
        .in_data   (push_data),
        .head_data (front_data)
    );

    deq_chain #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_back_chain (
        .aclk      (aclk),
        .ctrl      (back_ctrl),
        .wr_index  (count_reg),
        .in_data   (push_data),
        .head_data (back_data)
    );

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count exceeds depth");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && full && (op == OP_PUSH_FRONT || op == OP_PUSH_BACK))
        |=> (m_data.push_dropped && (count_reg == CNT_W'(DEPTH))))
        else $error("push on full deque not dropped");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.element_count == '0)))
        else $error("empty flag disagrees with count");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.read_miss) |-> (m_data.read_value == '0))
        else $error("miss carries nonzero read value");
`endif

endmodule
